>>> hw/rtl/atc_pkg.sv
// shared types, constants and helper functions of the atc block decoder
`timescale 1ns / 1ps

package atc_pkg;

    localparam int MAX_IMAGE_SIDE = 4096;
    localparam int SIDE_W         = $clog2(MAX_IMAGE_SIDE) + 1;
    localparam int COORD_W        = $clog2(MAX_IMAGE_SIDE);
    localparam int BLK_W          = COORD_W - 2;
    localparam int BLKN_W         = BLK_W + 1;
    localparam int NUM_PIXELS     = 16;
    localparam int PIX_IDX_W      = 4;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_EXPLICIT_ALPHA = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT   = 2'd2;

    localparam logic [15:0] ALT_MODE_BIT = 16'h8000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef rgb_t [3:0] palette_t;

    typedef struct packed {
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } pixel_t;

    function automatic logic [7:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    function automatic logic [SIDE_W-1:0] side_clamp(input logic [CFG_DATA_W-1:0] v);
        logic [SIDE_W-1:0] r;
        r = SIDE_W'(v);
        if (v == '0)
        begin
            r = SIDE_W'(1);
        end
        else if (SIDE_W'(v) > SIDE_W'(MAX_IMAGE_SIDE))
        begin
            r = SIDE_W'(MAX_IMAGE_SIDE);
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/atc_palette.sv
// four-entry palette built from the two endpoints of a colour block
`timescale 1ns / 1ps

module atc_palette
(
    input  logic [15:0]       c0,
    input  logic [15:0]       c1,
    output atc_pkg::palette_t pal
);

    atc_pkg::rgb_t e0;
    atc_pkg::rgb_t e1;

    function automatic logic [7:0] mix53(input logic [7:0] a, input logic [7:0] b);
        logic [10:0] s;
        s = 11'(a) * 11'd5 + 11'(b) * 11'd3;
        return s[10:3];
    endfunction

    function automatic logic [7:0] sub_quarter(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] q;
        q = {2'b00, b[7:2]};
        return (a > q) ? (a - q) : 8'd0;
    endfunction

    always_comb
    begin
        e0.red   = atc_pkg::widen5(c0[14:10]);
        e0.green = atc_pkg::widen5(c0[9:5]);
        e0.blue  = atc_pkg::widen5(c0[4:0]);
        e1.red   = atc_pkg::widen5(c1[15:11]);
        e1.green = atc_pkg::widen6(c1[10:5]);
        e1.blue  = atc_pkg::widen5(c1[4:0]);

        if ((c0 & atc_pkg::ALT_MODE_BIT) == '0)
        begin
            pal[0]       = e0;
            pal[1].red   = mix53(e0.red, e1.red);
            pal[1].green = mix53(e0.green, e1.green);
            pal[1].blue  = mix53(e0.blue, e1.blue);
            pal[2].red   = mix53(e1.red, e0.red);
            pal[2].green = mix53(e1.green, e0.green);
            pal[2].blue  = mix53(e1.blue, e0.blue);
            pal[3]       = e1;
        end
        else
        begin
            pal[0]       = '0;
            pal[1].red   = sub_quarter(e0.red, e1.red);
            pal[1].green = sub_quarter(e0.green, e1.green);
            pal[1].blue  = sub_quarter(e0.blue, e1.blue);
            pal[2]       = e0;
            pal[3]       = e1;
        end
    end

endmodule

>>> hw/rtl/atc_lane.sv
// one pixel lane: palette pick, alpha expansion and crop test
`timescale 1ns / 1ps

module atc_lane
(
    input  atc_pkg::palette_t                 pal,
    input  logic [1:0]                        sel,
    input  logic [3:0]                        nibble,
    input  logic                              explicit_alpha,
    input  logic [atc_pkg::COORD_W-1:0]       px,
    input  logic [atc_pkg::COORD_W-1:0]       py,
    input  logic [atc_pkg::SIDE_W-1:0]        width,
    input  logic [atc_pkg::SIDE_W-1:0]        height,
    output atc_pkg::pixel_t                   pix,
    output logic                              visible
);

    atc_pkg::rgb_t colour;

    always_comb
    begin
        colour    = pal[sel];
        pix.red   = colour.red;
        pix.green = colour.green;
        pix.blue  = colour.blue;
        pix.alpha = explicit_alpha ? {nibble, nibble} : 8'hff;
        pix.x     = px;
        pix.y     = py;
        visible   = ({1'b0, px} < width) && ({1'b0, py} < height);
    end

endmodule

>>> hw/rtl/atc_emitter.sv
// block buffer and output register: sends the visible pixels one per cycle while out_ready allows
`timescale 1ns / 1ps

module atc_emitter
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  atc_pkg::pixel_t                     lane_pix [atc_pkg::NUM_PIXELS],
    input  logic [atc_pkg::NUM_PIXELS-1:0]      lane_visible,
    input  logic                                last_image,
    output logic                                buf_free,
    output logic                                out_valid,
    input  logic                                out_ready,
    output atc_pkg::pixel_t                     out_pix,
    output logic                                out_last_block,
    output logic                                out_last_image
);

    atc_pkg::pixel_t                   buf_reg [atc_pkg::NUM_PIXELS];
    logic [atc_pkg::NUM_PIXELS-1:0]    mask_reg;
    logic [atc_pkg::NUM_PIXELS-1:0]    mask_next;
    logic                              last_image_reg;
    logic                              out_valid_reg;
    atc_pkg::pixel_t                   out_pix_reg;
    logic                              out_last_block_reg;
    logic                              out_last_image_reg;

    logic [atc_pkg::NUM_PIXELS-1:0]    low_bit;
    logic [atc_pkg::NUM_PIXELS-1:0]    remaining;
    logic [atc_pkg::PIX_IDX_W-1:0]     pick;
    logic                              out_free;
    logic                              take;

    always_comb
    begin
        low_bit   = mask_reg & (~mask_reg + 1'b1);
        remaining = mask_reg & ~low_bit;
        pick      = '0;
        for (int i = atc_pkg::NUM_PIXELS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                pick = atc_pkg::PIX_IDX_W'(i);
            end
        end
        out_free  = !out_valid_reg || out_ready;
        take      = (mask_reg != '0) && out_free;
        buf_free  = (mask_reg == '0) || (take && (remaining == '0));
        mask_next = take ? remaining : mask_reg;
        if (load)
        begin
            mask_next = lane_visible;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg <= mask_next;
            if (out_free)
            begin
                out_valid_reg <= take;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            buf_reg        <= lane_pix;
            last_image_reg <= last_image;
        end
        if (take)
        begin
            out_pix_reg        <= buf_reg[pick];
            out_last_block_reg <= (remaining == '0);
            out_last_image_reg <= (remaining == '0) && last_image_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_pix        = out_pix_reg;
    assign out_last_block = out_last_block_reg;
    assign out_last_image = out_last_image_reg;

endmodule

>>> hw/rtl/atc_texture_block_decoder.sv
// top level of the atc texture block decoder
`timescale 1ns / 1ps

// Decodes one compressed 4x4 atc block per input word into up to sixteen pixel words.
// Input word (s_*): colour block and alpha block; taken when s_tvalid and s_tready
// are high at a rising edge. Output word (m_*): one pixel in raster order within its
// block, tlast on the last visible pixel of the block, tuser on that pixel when the
// block is the last of the image. Blocks are placed by running block counters in
// raster order; pixels beyond the configured width and height are dropped.
// Configuration: cfg_we with cfg_index and cfg_data, which the user must drive only while the
// block is idle; the block itself does not enforce this. A taken word goes to the block buffer
// and each of its pixels from there to the output register that drives m_*. Throughput: one
// pixel per cycle while m_tready is high, set by the single output channel that serialises the
// sixteen decode lanes; a cropped block sends only its visible pixels, at least one as its
// first pixel is always inside the image. The next block is taken in the cycle its
// predecessor's last pixel moves to the output register.
// When m_tready is low the output register and the block buffer hold, and s_tready
// drops once the buffer is full. Reset clears the counters, the buffer and the
// output, and sets opaque rgb mode at 4096 x 4096.
module atc_texture_block_decoder
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [127:0]                        s_tdata,   // color_block, alpha_block
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [55:0]                         m_tdata,   // red, green, blue, alpha, pixel_x, pixel_y
    output logic                                m_tlast,
    output logic                                m_tuser,   // last_of_image
    input  logic                                cfg_we,
    input  logic [atc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [atc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic                              explicit_alpha_reg;
    logic [atc_pkg::CFG_DATA_W-1:0]    image_width_reg;
    logic [atc_pkg::CFG_DATA_W-1:0]    image_height_reg;
    logic [atc_pkg::BLK_W-1:0]         block_column_reg;
    logic [atc_pkg::BLK_W-1:0]         block_column_next;
    logic [atc_pkg::BLK_W-1:0]         block_row_reg;
    logic [atc_pkg::BLK_W-1:0]         block_row_next;

    logic [atc_pkg::SIDE_W-1:0]        width_c;
    logic [atc_pkg::SIDE_W-1:0]        height_c;
    logic [atc_pkg::BLKN_W-1:0]        blk_cols;
    logic [atc_pkg::BLKN_W-1:0]        blk_rows;
    logic [atc_pkg::BLK_W-1:0]         col_eff;
    logic [atc_pkg::BLK_W-1:0]         row_eff;
    logic [atc_pkg::BLKN_W-1:0]        col_inc;
    logic [atc_pkg::BLKN_W-1:0]        row_inc;
    logic                              last_image;
    logic                              accept;

    logic [63:0]                       color_block;
    logic [63:0]                       alpha_block;
    atc_pkg::palette_t                 pal;
    atc_pkg::pixel_t                   lane_pix [atc_pkg::NUM_PIXELS];
    logic [atc_pkg::NUM_PIXELS-1:0]    lane_visible;

    logic                              buf_free;
    atc_pkg::pixel_t                   out_pix;

    assign color_block = s_tdata[63:0];
    assign alpha_block = s_tdata[127:64];
    assign accept      = s_tvalid && s_tready;
    assign s_tready    = buf_free;

    always_comb
    begin
        width_c  = atc_pkg::side_clamp(image_width_reg);
        height_c = atc_pkg::side_clamp(image_height_reg);
        blk_cols = atc_pkg::BLKN_W'((width_c + atc_pkg::SIDE_W'(3)) >> 2);
        blk_rows = atc_pkg::BLKN_W'((height_c + atc_pkg::SIDE_W'(3)) >> 2);

        // counters left beyond a smaller size start over
        col_eff = ({1'b0, block_column_reg} >= blk_cols) ? '0 : block_column_reg;
        row_eff = ({1'b0, block_row_reg} >= blk_rows) ? '0 : block_row_reg;

        last_image = ({1'b0, col_eff} == blk_cols - 1'b1)
                  && ({1'b0, row_eff} == blk_rows - 1'b1);

        col_inc = {1'b0, col_eff} + 1'b1;
        row_inc = {1'b0, row_eff} + 1'b1;
        block_column_next = col_inc[atc_pkg::BLK_W-1:0];
        block_row_next    = row_eff;
        if (col_inc >= blk_cols)
        begin
            block_column_next = '0;
            block_row_next    = (row_inc >= blk_rows) ? '0 : row_inc[atc_pkg::BLK_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            explicit_alpha_reg <= 1'b0;
            image_width_reg    <= atc_pkg::CFG_DATA_W'(atc_pkg::MAX_IMAGE_SIDE);
            image_height_reg   <= atc_pkg::CFG_DATA_W'(atc_pkg::MAX_IMAGE_SIDE);
            block_column_reg   <= '0;
            block_row_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    atc_pkg::REG_EXPLICIT_ALPHA: explicit_alpha_reg <= cfg_data[0];
                    atc_pkg::REG_IMAGE_WIDTH:    image_width_reg    <= cfg_data;
                    atc_pkg::REG_IMAGE_HEIGHT:   image_height_reg   <= cfg_data;
                    default:                     ;
                endcase
            end
            if (accept)
            begin
                block_column_reg <= block_column_next;
                block_row_reg    <= block_row_next;
            end
        end
    end

    atc_palette u_palette
    (
        .c0  (color_block[15:0]),
        .c1  (color_block[31:16]),
        .pal (pal)
    );

    for (genvar p = 0; p < atc_pkg::NUM_PIXELS; p++)
    begin : g_lane
        atc_lane u_lane
        (
            .pal            (pal),
            .sel            (color_block[32 + 2*p +: 2]),
            .nibble         (alpha_block[4*p +: 4]),
            .explicit_alpha (explicit_alpha_reg),
            .px             ({col_eff, 2'(p % 4)}),
            .py             ({row_eff, 2'(p / 4)}),
            .width          (width_c),
            .height         (height_c),
            .pix            (lane_pix[p]),
            .visible        (lane_visible[p])
        );
    end

    atc_emitter u_emitter
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (accept),
        .lane_pix       (lane_pix),
        .lane_visible   (lane_visible),
        .last_image     (last_image),
        .buf_free       (buf_free),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_pix        (out_pix),
        .out_last_block (m_tlast),
        .out_last_image (m_tuser)
    );

    assign m_tdata = {out_pix.y, out_pix.x, out_pix.alpha,
                      out_pix.blue, out_pix.green, out_pix.red};

endmodule

>>> dv/atc_pixel_checker.sv
// checker for the atc block decoder: predicts the pixel words and compares them
`timescale 1ns / 1ps

module atc_pixel_checker
    import atc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [127:0]           s_tdata,   // color_block, alpha_block
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [55:0]            m_tdata,   // red, green, blue, alpha, pixel_x, pixel_y
    input  logic                   m_tlast,
    input  logic                   m_tuser,   // last_of_image
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     error_count,
    output int                     pending_count
);

    typedef struct {
        pixel_t pix;
        logic   last_blk;
        logic   last_img;
    } pixel_word_t;

    pixel_word_t             expected_pixels[$];

    logic                    alpha_explicit;
    logic [CFG_DATA_W-1:0]   width_reg;
    logic [CFG_DATA_W-1:0]   height_reg;
    logic [BLK_W-1:0]        blk_col;
    logic [BLK_W-1:0]        blk_row;

    function automatic int side_of(input logic [CFG_DATA_W-1:0] v);
        if (v == '0)
        begin
            return 1;
        end
        if (int'(v) > MAX_IMAGE_SIDE)
        begin
            return MAX_IMAGE_SIDE;
        end
        return int'(v);
    endfunction

    function automatic int rep5(input logic [4:0] v);
        return int'({v, v[4:2]});
    endfunction

    function automatic int rep6(input logic [5:0] v);
        return int'({v, v[5:4]});
    endfunction

    task automatic predict_block(input logic [63:0] cb, input logic [63:0] ab);
        int          w;
        int          h;
        int          bxn;
        int          byn;
        int          px;
        int          py;
        int          sel;
        int          n;
        int          q;
        int          next_col;
        int          next_row;
        int          e0[3];
        int          e1[3];
        int          pal[4][3];
        logic [15:0] c0;
        logic [15:0] c1;
        logic [31:0] idx;
        logic        last_img;
        pixel_word_t words[16];
        w   = side_of(width_reg);
        h   = side_of(height_reg);
        bxn = (w + 3) / 4;
        byn = (h + 3) / 4;
        c0  = cb[15:0];
        c1  = cb[31:16];
        idx = cb[63:32];
        if (int'(blk_col) >= bxn)
        begin
            blk_col = '0;
        end
        if (int'(blk_row) >= byn)
        begin
            blk_row = '0;
        end
        e0[0] = rep5(c0[14:10]);
        e0[1] = rep5(c0[9:5]);
        e0[2] = rep5(c0[4:0]);
        e1[0] = rep5(c1[15:11]);
        e1[1] = rep6(c1[10:5]);
        e1[2] = rep5(c1[4:0]);
        for (int ch = 0; ch < 3; ch++)
        begin
            if ((c0 & ALT_MODE_BIT) == '0)
            begin
                pal[0][ch] = e0[ch];
                pal[1][ch] = (5 * e0[ch] + 3 * e1[ch]) / 8;
                pal[2][ch] = (3 * e0[ch] + 5 * e1[ch]) / 8;
                pal[3][ch] = e1[ch];
            end
            else
            begin
                q          = e1[ch] / 4;
                pal[0][ch] = 0;
                pal[1][ch] = (e0[ch] > q) ? e0[ch] - q : 0;
                pal[2][ch] = e0[ch];
                pal[3][ch] = e1[ch];
            end
        end
        last_img = (int'(blk_col) == bxn - 1) && (int'(blk_row) == byn - 1);
        n = 0;
        for (int p = 0; p < NUM_PIXELS; p++)
        begin
            px  = int'(blk_col) * 4 + (p % 4);
            py  = int'(blk_row) * 4 + (p / 4);
            sel = int'(idx[2*p +: 2]);
            if (px < w && py < h)
            begin
                words[n].pix.red   = 8'(pal[sel][0]);
                words[n].pix.green = 8'(pal[sel][1]);
                words[n].pix.blue  = 8'(pal[sel][2]);
                words[n].pix.alpha = alpha_explicit ? 8'(int'(ab[4*p +: 4]) * 17) : 8'd255;
                words[n].pix.x     = COORD_W'(px);
                words[n].pix.y     = COORD_W'(py);
                words[n].last_blk  = 1'b0;
                words[n].last_img  = 1'b0;
                n++;
            end
        end
        if (n > 0)
        begin
            words[n-1].last_blk = 1'b1;
            words[n-1].last_img = last_img;
        end
        for (int i = 0; i < n; i++)
        begin
            expected_pixels.push_back(words[i]);
        end
        next_col = int'(blk_col) + 1;
        if (next_col >= bxn)
        begin
            blk_col  = '0;
            next_row = int'(blk_row) + 1;
            blk_row  = (next_row >= byn) ? '0 : BLK_W'(next_row);
        end
        else
        begin
            blk_col = BLK_W'(next_col);
        end
    endtask

    task automatic check_field(input string label, input int want, input int got);
        if (want != got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_explicit = 1'b0;
            width_reg      = CFG_DATA_W'(MAX_IMAGE_SIDE);
            height_reg     = CFG_DATA_W'(MAX_IMAGE_SIDE);
            blk_col        = '0;
            blk_row        = '0;
            expected_pixels.delete();
            error_count    = 0;
            pending_count  = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_EXPLICIT_ALPHA: alpha_explicit = cfg_data[0];
                    REG_IMAGE_WIDTH:    width_reg      = cfg_data;
                    REG_IMAGE_HEIGHT:   height_reg     = cfg_data;
                    default:            ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                predict_block(s_tdata[63:0], s_tdata[127:64]);
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    error_count++;
                    $display("%0t: pixel word with none expected, actual x %0d y %0d", $time,
                             m_tdata[43:32], m_tdata[55:44]);
                end
                else
                begin
                    pixel_word_t want;
                    want = expected_pixels.pop_front();
                    check_field("red", want.pix.red, m_tdata[7:0]);
                    check_field("green", want.pix.green, m_tdata[15:8]);
                    check_field("blue", want.pix.blue, m_tdata[23:16]);
                    check_field("alpha", want.pix.alpha, m_tdata[31:24]);
                    check_field("pixel_x", want.pix.x, m_tdata[43:32]);
                    check_field("pixel_y", want.pix.y, m_tdata[55:44]);
                    check_field("last_of_block", want.last_blk, m_tlast);
                    check_field("last_of_image", want.last_img, m_tuser);
                end
            end
            pending_count = expected_pixels.size();
        end
    end

endmodule

>>> dv/testbench.sv
// top of the atc block decoder testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;
    import atc_pkg::*;

    localparam int                     WATCHDOG_LIMIT = 2000;
    localparam int                     SETTLE_CYCLES  = 8;
    localparam int                     PHASE_BLOCKS   = 30;
    localparam int                     RANDOM_PHASES  = 12;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE      = 2'd3;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [127:0]           s_tdata   = '0;   // color_block, alpha_block
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [55:0]            m_tdata;          // red, green, blue, alpha, pixel_x, pixel_y
    logic                   m_tlast;
    logic                   m_tuser;          // last_of_image
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int error_count;
    int pending_count;
    int burst_left = 0;
    int idle_cycles = 0;
    int rx_cycle = 0;
    int rx_mode = 0;
    int rx_stall = 0;

    always #10 clk = ~clk;

    atc_texture_block_decoder dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    atc_pixel_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    // receiver: changes its stall pattern every so often
    always @(posedge clk)
    begin
        rx_cycle++;
        if (rx_cycle % 97 == 0)
        begin
            rx_mode = $urandom_range(0, 3);
        end
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= (rx_cycle % 3 != 0);
            default:
            begin
                if (rx_stall > 0)
                begin
                    rx_stall--;
                    m_tready <= 1'b0;
                end
                else
                begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 7) == 0)
                    begin
                        rx_stall = $urandom_range(1, 20);
                    end
                end
            end
        endcase
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !rst_n)
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_block(input logic [63:0] color, input logic [63:0] alpha);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {alpha, color};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic wait_idle();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic set_image(input logic mode, input logic [CFG_DATA_W-1:0] width,
                             input logic [CFG_DATA_W-1:0] height);
        wait_idle();
        write_reg(REG_EXPLICIT_ALPHA, CFG_DATA_W'(mode));
        write_reg(REG_IMAGE_WIDTH, width);
        write_reg(REG_IMAGE_HEIGHT, height);
        if ($urandom_range(0, 2) == 0)
        begin
            write_reg(REG_SPARE, CFG_DATA_W'($urandom));
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_side();
        case ($urandom_range(0, 9))
            0:       return CFG_DATA_W'(1);
            1:       return CFG_DATA_W'(MAX_IMAGE_SIDE);
            2:       return '0;
            3:       return '1;
            4:       return CFG_DATA_W'($urandom_range(MAX_IMAGE_SIDE + 1, 8191));
            default: return CFG_DATA_W'($urandom_range(1, 24));
        endcase
    endfunction

    function automatic logic [63:0] random_color();
        logic [63:0] cb;
        cb = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: cb[15:0]  = cb[15:0] | ALT_MODE_BIT;
            1: cb[15:0]  = cb[15:0] & ~ALT_MODE_BIT;
            2: cb[31:16] = 16'hffff;
            3: cb[15:0]  = '0;
            default: ;
        endcase
        return cb;
    endfunction

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // opaque mode at the reset size
        send_block(64'h0, {$urandom, $urandom});
        send_block('1, '0);
        send_block({32'he4e4e4e4, 16'h07e0, 16'h7c1f}, '1);
        send_block({32'h1b1b1b1b, 16'hf81f, 16'h0421}, {$urandom, $urandom});

        // explicit alpha, cropped 2x2 block image
        set_image(1'b1, 13'd6, 13'd5);
        send_block({32'h1b1b1b1b, 16'hffff, ALT_MODE_BIT | 16'h0421}, '0);
        send_block({32'he4e4e4e4, 16'h0000, 16'hffff}, '1);
        send_block({32'hffffffff, 16'h001f, 16'h8000}, 64'hfedcba9876543210);
        send_block({32'h00000000, 16'hffe0, 16'h7fff}, 64'h0123456789abcdef);
        send_block({32'h55555555, 16'h1234, 16'h5678}, {$urandom, $urandom});
        send_block({32'haaaaaaaa, 16'hffff, 16'hffff}, 64'hf0f0f0f0f0f0f0f0);
        send_block({32'h9c9c9c9c, 16'habcd, 16'hdcba}, 64'h0f0f0f0f0f0f0f0f);
        send_block({$urandom, $urandom}, {$urandom, $urandom});

        // zero and oversize sides saturate
        set_image(1'b0, '0, '1);
        repeat (4) send_block({$urandom, $urandom}, {$urandom, $urandom});
        set_image(1'b1, '1, '0);
        repeat (4) send_block({$urandom, $urandom}, {$urandom, $urandom});

        set_image(1'b0, 13'd1, 13'd1);
        repeat (PHASE_BLOCKS) send_block(random_color(), {$urandom, $urandom});
        set_image(1'b1, 13'd4096, 13'd4);
        repeat (PHASE_BLOCKS) send_block(random_color(), {$urandom, $urandom});
        for (int ph = 0; ph < RANDOM_PHASES - 2; ph++)
        begin
            set_image(1'($urandom_range(0, 1)), pick_side(), pick_side());
            repeat (PHASE_BLOCKS) send_block(random_color(), {$urandom, $urandom});
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (error_count == 0 && pending_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
